>>> rtl/core/encoder_switch_input_qualifier_defines.svh
// Assertion macros shared by the encoder switch input qualifier RTL
`ifndef ENCODER_SWITCH_INPUT_QUALIFIER_DEFINES_SVH
`define ENCODER_SWITCH_INPUT_QUALIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle check, held off during reset
`define ESIQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// next-cycle check after a trigger condition
`define ESIQ_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);
`else
`define ESIQ_ASSERT(lbl, prop, msg)
`define ESIQ_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

>>> rtl/core/esiq_pkg.sv
// Shared types, codes and defaults for the encoder switch input qualifier
`timescale 1ns / 1ps
`default_nettype none
package esiq_pkg;

  localparam int SW_MAX      = 3;
  localparam int ENC_MAX     = 2;
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = 2;
  localparam int QDEPTH      = 2;

  localparam int DEF_SWITCH_COUNT  = 3;
  localparam int DEF_ENCODER_COUNT = 2;
  localparam int DEF_TIME_BITS     = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENC_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SW_DEBOUNCE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_LIMIT   = 2'd2;

  localparam logic [23:0] ENC_DEBOUNCE_RST = 24'd2000;
  localparam logic [23:0] SW_DEBOUNCE_RST  = 24'd10000;
  localparam logic [31:0] HOLD_LIMIT_RST   = 32'd15000000;

  // quadrature phase codes, {A, B}
  localparam logic [1:0] PH_DETENT = 2'b11;
  localparam logic [1:0] PH_CW     = 2'b10;
  localparam logic [1:0] PH_CCW    = 2'b01;

  typedef logic [3:0] event_code_t;

  localparam event_code_t EV_NONE           = 4'd0;
  localparam event_code_t EV_ENC1_CW        = 4'd1;
  localparam event_code_t EV_ENC1_CCW       = 4'd2;
  localparam event_code_t EV_BUTTON_PRESS   = 4'd5;
  localparam event_code_t EV_BUTTON_RELEASE = 4'd6;
  localparam event_code_t EV_RESTART        = 4'd11;

  // one classified sample: its events in order, index of the last one, idle time
  typedef struct packed {
    event_code_t [MAX_RESULTS-1:0] ev;
    logic [RES_IDX_W-1:0]          last_idx;
    logic [31:0]                   idle_us;
  } q_rec_t;

endpackage
`default_nettype wire

>>> rtl/core/esiq_if.sv
// Request channel interfaces: sample input and event output
`timescale 1ns / 1ps
`default_nettype none
interface esiq_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_us;
  logic [2:0]  edge_line;
  logic        enc1_a;
  logic        enc1_b;
  logic        enc2_a;
  logic        enc2_b;
  logic        button_level;
  logic        enc1_sw_level;
  logic        enc2_sw_level;
  logic        clear_idle;

  modport source (
    output valid, now_us, edge_line, enc1_a, enc1_b, enc2_a, enc2_b,
    output button_level, enc1_sw_level, enc2_sw_level, clear_idle,
    input  ready
  );
  modport sink (
    input  valid, now_us, edge_line, enc1_a, enc1_b, enc2_a, enc2_b,
    input  button_level, enc1_sw_level, enc2_sw_level, clear_idle,
    output ready
  );
endinterface

interface esiq_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [31:0] idle_us;
  logic        last_result;

  modport source (output valid, event_code, idle_us, last_result, input ready);
  modport sink (input valid, event_code, idle_us, last_result, output ready);
endinterface
`default_nettype wire

>>> rtl/core/esiq_front.sv
// Front end: takes samples, updates encoder/switch state, builds the event record
`timescale 1ns / 1ps
`default_nettype none
module esiq_front #(
  parameter int SWITCH_COUNT  = esiq_pkg::DEF_SWITCH_COUNT,
  parameter int ENCODER_COUNT = esiq_pkg::DEF_ENCODER_COUNT,
  parameter int TIME_BITS     = esiq_pkg::DEF_TIME_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  esiq_sample_if.sink                        sample,
  input  logic                               cfg_we,
  input  logic [esiq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [esiq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               q_full,
  output logic                               push,
  output esiq_pkg::q_rec_t                   push_rec
);
  import esiq_pkg::*;

  localparam int NSW   = (SWITCH_COUNT < SW_MAX) ? SWITCH_COUNT : SW_MAX;
  localparam int NENC  = (ENCODER_COUNT < ENC_MAX) ? ENCODER_COUNT : ENC_MAX;
  localparam int NLINE = 2 * NENC;
  localparam int CMPW  = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef logic [TIME_BITS-1:0] stamp_t;

  function automatic logic reached(stamp_t d, logic [31:0] lim);
    return CMPW'(d) >= CMPW'(lim);
  endfunction

  // configuration
  logic [23:0] enc_debounce;
  logic [23:0] sw_debounce;
  logic [31:0] hold_limit;

  // sample state
  logic             started;
  logic [1:0]       phase [NENC];
  stamp_t           acc_time [NLINE];
  logic [NSW-1:0]   sw_stable;
  logic [NSW-1:0]   sw_cand;
  stamp_t           sw_since [NSW];
  logic             hold_active;
  stamp_t           hold_start;
  stamp_t           last_activity;

  logic [1:0]       phase_next [NENC];
  stamp_t           acc_time_next [NLINE];
  logic [NSW-1:0]   sw_stable_next;
  logic [NSW-1:0]   sw_cand_next;
  stamp_t           sw_since_next [NSW];
  logic             hold_active_next;
  stamp_t           hold_start_next;
  stamp_t           last_activity_next;

  stamp_t           now;
  logic [3:0]       lvl;
  logic [2:0]       swl;
  logic             line_ok;
  logic [2:0]       line_idx;
  logic [NLINE-1:0] line_hit;
  logic [NLINE-1:0] line_pass;
  logic [NENC-1:0]  enc_take;
  logic [31:0]      hold_lim;

  logic             enc_ev;
  event_code_t      enc_code;
  logic [NSW-1:0]   sw_ev;
  event_code_t      sw_code [NSW];
  logic             restart;
  stamp_t           idle_stamp;

  assign sample.ready = !q_full;
  assign push         = sample.valid && sample.ready;

  assign now      = stamp_t'(sample.now_us);
  assign lvl      = {sample.enc2_b, sample.enc2_a, sample.enc1_b, sample.enc1_a};
  assign swl      = {sample.enc2_sw_level, sample.enc1_sw_level, sample.button_level};
  assign line_ok  = (sample.edge_line != 3'd0) && (sample.edge_line <= 3'(NLINE));
  assign line_idx = sample.edge_line - 3'd1;
  assign hold_lim = (hold_limit == 32'd0) ? 32'd1 : hold_limit;

  always_comb begin
    for (int l = 0; l < NLINE; l++) begin
      line_hit[l]  = line_ok && (line_idx == 3'(l));
      line_pass[l] = reached(now - acc_time[l], 32'(enc_debounce));
    end
    for (int j = 0; j < NENC; j++) begin
      enc_take[j] = |(line_hit[2*j +: 2] & line_pass[2*j +: 2]);
    end
  end

  always_comb begin
    logic [1:0] np;
    np                 = 2'b00;
    phase_next         = phase;
    acc_time_next      = acc_time;
    sw_stable_next     = sw_stable;
    sw_cand_next       = sw_cand;
    sw_since_next      = sw_since;
    hold_active_next   = hold_active;
    hold_start_next    = hold_start;
    last_activity_next = last_activity;
    enc_ev             = 1'b0;
    enc_code           = EV_NONE;
    sw_ev              = '0;
    restart            = 1'b0;
    for (int k = 0; k < NSW; k++) begin
      sw_code[k] = EV_NONE;
    end

    if (!started) begin
      // first sample only loads levels
      for (int j = 0; j < NENC; j++) begin
        phase_next[j] = {lvl[2*j], lvl[2*j+1]};
      end
      for (int k = 0; k < NSW; k++) begin
        sw_stable_next[k] = swl[k];
        sw_cand_next[k]   = swl[k];
        sw_since_next[k]  = now;
      end
      hold_active_next   = !swl[0];
      hold_start_next    = now;
      last_activity_next = now;
    end else begin
      if (sample.clear_idle) begin
        last_activity_next = now;
      end
      for (int l = 0; l < NLINE; l++) begin
        if (line_hit[l] && line_pass[l]) begin
          acc_time_next[l] = now;
        end
      end
      for (int j = 0; j < NENC; j++) begin
        if (enc_take[j]) begin
          np            = {lvl[2*j], lvl[2*j+1]};
          phase_next[j] = np;
          if (phase[j] == PH_DETENT && np == PH_CW) begin
            enc_ev   = 1'b1;
            enc_code = 4'(EV_ENC1_CW + 2 * j);
          end else if (phase[j] == PH_DETENT && np == PH_CCW) begin
            enc_ev   = 1'b1;
            enc_code = 4'(EV_ENC1_CCW + 2 * j);
          end
        end
      end
      if (enc_ev) begin
        last_activity_next = now;
      end
      for (int k = 0; k < NSW; k++) begin
        if (swl[k] != sw_cand[k]) begin
          // new candidate level restarts the stability timer
          sw_cand_next[k]  = swl[k];
          sw_since_next[k] = now;
        end else if (swl[k] != sw_stable[k] &&
                     reached(now - sw_since[k], 32'(sw_debounce))) begin
          sw_stable_next[k]  = swl[k];
          sw_ev[k]           = 1'b1;
          sw_code[k]         = swl[k] ? 4'(EV_BUTTON_RELEASE + 2 * k)
                                      : 4'(EV_BUTTON_PRESS + 2 * k);
          last_activity_next = now;
          if (k == 0) begin
            hold_active_next = !swl[k];
            hold_start_next  = now;
          end
        end
      end
      // a fresh button edge restarts the hold timer, so no restart that sample
      if (hold_active && !sw_ev[0] && reached(now - hold_start, hold_lim)) begin
        hold_active_next = 1'b0;
        restart          = 1'b1;
      end
    end
  end

  // pack events in order: encoder, switches, restart
  always_comb begin
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      push_rec.ev[i] = EV_NONE;
    end
    if (enc_ev) begin
      push_rec.ev[n[1:0]] = enc_code;
      n = n + 3'd1;
    end
    for (int k = 0; k < NSW; k++) begin
      if (sw_ev[k] && n < 3'(MAX_RESULTS)) begin
        push_rec.ev[n[1:0]] = sw_code[k];
        n = n + 3'd1;
      end
    end
    if (restart && n < 3'(MAX_RESULTS)) begin
      push_rec.ev[n[1:0]] = EV_RESTART;
      n = n + 3'd1;
    end
    push_rec.last_idx = (n == 3'd0) ? '0 : RES_IDX_W'(n - 3'd1);
    idle_stamp        = now - last_activity_next;
    push_rec.idle_us  = 32'(idle_stamp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_debounce <= ENC_DEBOUNCE_RST;
      sw_debounce  <= SW_DEBOUNCE_RST;
      hold_limit   <= HOLD_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENC_DEBOUNCE: enc_debounce <= cfg_data[23:0];
        CFG_SW_DEBOUNCE:  sw_debounce  <= cfg_data[23:0];
        CFG_HOLD_LIMIT:   hold_limit   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      sw_stable     <= '1;
      sw_cand       <= '1;
      hold_active   <= 1'b0;
      hold_start    <= '0;
      last_activity <= '0;
      for (int j = 0; j < NENC; j++) begin
        phase[j] <= PH_DETENT;
      end
      for (int l = 0; l < NLINE; l++) begin
        acc_time[l] <= '0;
      end
      for (int k = 0; k < NSW; k++) begin
        sw_since[k] <= '0;
      end
    end else if (push) begin
      started       <= 1'b1;
      phase         <= phase_next;
      acc_time      <= acc_time_next;
      sw_stable     <= sw_stable_next;
      sw_cand       <= sw_cand_next;
      sw_since      <= sw_since_next;
      hold_active   <= hold_active_next;
      hold_start    <= hold_start_next;
      last_activity <= last_activity_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/esiq_queue.sv
// Two-entry record queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_switch_input_qualifier_defines.svh"
module esiq_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  esiq_pkg::q_rec_t push_rec,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output esiq_pkg::q_rec_t head
);
  import esiq_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_rec_t        mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `ESIQ_ASSERT(a_no_push_full, push |-> !full, "record pushed into full queue")
  `ESIQ_ASSERT(a_no_pop_empty, pop |-> !empty, "record popped from empty queue")
  `ESIQ_ASSERT_NEXT(a_count_hold, (!push && !pop), $stable(count), "queue count moved while idle")
  `ESIQ_ASSERT_NEXT(a_push_lands, (push && !pop), !empty, "pushed record lost")

endmodule
`default_nettype wire

>>> rtl/core/esiq_back.sv
// Back end: plays each record out as one event request per cycle while the receiver is ready
`timescale 1ns / 1ps
`default_nettype none
module esiq_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  esiq_pkg::q_rec_t head,
  output logic             pop,
  esiq_event_if.source     result
);
  import esiq_pkg::*;

  logic [RES_IDX_W-1:0] idx;
  logic                 load;
  logic                 at_last;

  assign load    = !empty && (!result.valid || result.ready);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        idx          <= at_last ? '0 : idx + RES_IDX_W'(1);
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.event_code  <= head.ev[idx];
      result.idle_us     <= head.idle_us;
      result.last_result <= at_last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/encoder_switch_input_qualifier.sv
// Top level of the encoder and switch input qualifier.
// A sample's record is registered in the queue, then its first event in the output register.
// Throughput: one sample per cycle when each yields one event and the receiver takes
// every event; a sample with n events (n is 1 to 4) plays them out one at a time.
// Reset (rst, synchronous): registers to defaults, state cleared, queue emptied.
`timescale 1ns / 1ps
`default_nettype none
module encoder_switch_input_qualifier #(
  parameter int SWITCH_COUNT  = esiq_pkg::DEF_SWITCH_COUNT,
  parameter int ENCODER_COUNT = esiq_pkg::DEF_ENCODER_COUNT,
  parameter int TIME_BITS     = esiq_pkg::DEF_TIME_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  esiq_sample_if.sink                      sample,
  esiq_event_if.source                     result,
  input  logic                             cfg_we,
  input  logic [esiq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [esiq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import esiq_pkg::*;

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  q_rec_t push_rec;
  q_rec_t head;

  esiq_front #(
    .SWITCH_COUNT  (SWITCH_COUNT),
    .ENCODER_COUNT (ENCODER_COUNT),
    .TIME_BITS     (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  esiq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .empty    (q_empty),
    .pop      (pop),
    .head     (head)
  );

  esiq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire

>>> verif/encoder_switch_input_qualifier_test.sv
// Self-checking testbench for the encoder and switch input qualifier
`timescale 1ns / 1ps
module encoder_switch_input_qualifier_test;
  import esiq_pkg::*;

  localparam logic [2:0] LINE_NONE = 3'd0;
  localparam logic [1:0] PH_BOTH_LOW = 2'b00;

  // enc = {enc1_a, enc1_b, enc2_a, enc2_b}, sw = {button, enc1_sw, enc2_sw}
  typedef struct packed {
    logic [31:0] now_us;
    logic [2:0]  edge_line;
    logic [3:0]  enc;
    logic [2:0]  sw;
    logic        clear_idle;
  } sample_t;

  typedef struct packed {
    sample_t     s;
    logic        typed;
    event_code_t code;
    logic [31:0] idle;
  } plan_row_t;

  typedef struct packed {
    event_code_t code;
    logic [31:0] idle;
    logic        last;
  } event_rec_t;

  typedef struct packed {
    logic [31:0] enc_db;
    logic [31:0] sw_db;
    logic [31:0] hold;
    int unsigned scale;
    int unsigned count;
  } phase_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  esiq_sample_if sample_ch ();
  esiq_event_if event_ch ();

  encoder_switch_input_qualifier u_top (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .result   (event_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // qualifier state as the block should hold it
  logic        seen_first = 1'b0;
  logic [1:0]  enc_phase [ENC_MAX] = '{PH_DETENT, PH_DETENT};
  logic [31:0] line_time [2*ENC_MAX] = '{32'd0, 32'd0, 32'd0, 32'd0};
  logic        sw_stable [SW_MAX] = '{1'b1, 1'b1, 1'b1};
  logic        sw_cand [SW_MAX] = '{1'b1, 1'b1, 1'b1};
  logic [31:0] sw_since [SW_MAX] = '{32'd0, 32'd0, 32'd0};
  logic        hold_armed = 1'b0;
  logic [31:0] hold_from = 32'd0;
  logic [31:0] active_at = 32'd0;
  logic [23:0] enc_debounce = ENC_DEBOUNCE_RST;
  logic [23:0] sw_debounce = SW_DEBOUNCE_RST;
  logic [31:0] hold_limit = HOLD_LIMIT_RST;

  event_rec_t  pending_events [$];
  event_rec_t  want;
  int unsigned bad_results = 0;
  bit          steady = 1'b0;
  int unsigned holdoff_asked = 0;
  int unsigned holdoff_taken = 0;
  int unsigned stall_left = 0;

  // random stimulus pin levels and running timestamp
  logic [3:0]  pin_enc = 4'b1111;
  logic [2:0]  pin_sw = 3'b111;
  logic [31:0] clock_us = 32'd0;

  plan_row_t directed_plan [24] = '{
    '{'{32'd1000, 3'd1, 4'b1111, 3'b111, 1'b0}, 1'b1, EV_NONE, 32'd0},
    '{'{32'd1500, 3'd1, 4'b1011, 3'b111, 1'b0}, 1'b1, EV_NONE, 32'd500},
    '{'{32'd3000, 3'd1, 4'b1011, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd3100, 3'd2, 4'b1111, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd6000, 3'd2, 4'b0111, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd6500, 3'd3, 4'b0110, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd9000, 3'd4, 4'b0100, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd9500, 3'd5, 4'b0111, 3'b111, 1'b0}, 1'b1, EV_NONE, 32'd3000},
    '{'{32'd9600, 3'd7, 4'b0111, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd12000, 3'd1, 4'b1100, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd12500, 3'd0, 4'b1100, 3'b011, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd17500, 3'd0, 4'b1100, 3'b011, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd22500, 3'd0, 4'b1100, 3'b000, 1'b0}, 1'b0, EV_NONE, 32'd0},
    // rotation, two switch presses and the restart in one request
    '{'{32'd15022500, 3'd2, 4'b0100, 3'b000, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd15030000, 3'd0, 4'b0100, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd15040000, 3'd0, 4'b0100, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd15050000, 3'd0, 4'b0100, 3'b111, 1'b1}, 1'b1, EV_NONE, 32'd0},
    // timestamp wrap: the edge just after the wrap bounces
    '{'{32'hFFFF_FFFF, 3'd3, 4'b0111, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'h0000_0100, 3'd3, 4'b0110, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd3000, 3'd3, 4'b0110, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd6000, 3'd4, 4'b0111, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd6100, 3'd3, 4'b0101, 3'b111, 1'b0}, 1'b0, EV_NONE, 32'd0},
    '{'{32'd3000, 3'd7, 4'b1111, 3'b111, 1'b1}, 1'b1, EV_NONE, 32'd0},
    '{'{32'd0, 3'd0, 4'b0000, 3'b000, 1'b0}, 1'b0, EV_NONE, 32'd0}
  };

  // phase 0 runs on the reset values and writes nothing
  phase_t phases [4] = '{
    '{32'd2000, 32'd10000, 32'd15000000, 3000, 110},
    '{32'd0, 32'd0, 32'd0, 50, 110},
    '{32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF, 6000000, 110},
    '{32'd300, 32'd800, 32'd5000, 400, 130}
  };

  function automatic int unsigned qualify_sample(input sample_t s,
                                                 output event_code_t codes [MAX_RESULTS],
                                                 output logic [31:0] idle);
    int unsigned n;
    int          e;
    int          k;
    logic [2:0]  lvl;
    logic [1:0]  li;
    logic [1:0]  np;
    logic [31:0] gap;
    logic [31:0] lim;
    event_code_t code;
    n = 0;
    lvl = {s.sw[0], s.sw[1], s.sw[2]};
    for (k = 0; k < MAX_RESULTS; k++) codes[k] = EV_NONE;
    if (!seen_first) begin
      seen_first = 1'b1;
      enc_phase[0] = s.enc[3:2];
      enc_phase[1] = s.enc[1:0];
      for (k = 0; k < SW_MAX; k++) begin
        sw_stable[k] = lvl[k];
        sw_cand[k] = lvl[k];
        sw_since[k] = s.now_us;
      end
      hold_armed = !lvl[0];
      hold_from = s.now_us;
      active_at = s.now_us;
    end else begin
      if (s.clear_idle) active_at = s.now_us;
      if (s.edge_line >= 3'd1 && s.edge_line <= 3'd4) begin
        li = 2'(s.edge_line - 3'd1);
        e = int'(li[1]);
        gap = s.now_us - line_time[li];
        if (gap >= {8'd0, enc_debounce}) begin
          np = (e == 0) ? s.enc[3:2] : s.enc[1:0];
          line_time[li] = s.now_us;
          if (np != enc_phase[e]) begin
            code = EV_NONE;
            if (enc_phase[e] == PH_DETENT) begin
              if (np == PH_CW) code = EV_ENC1_CW + event_code_t'(2 * e);
              else if (np == PH_CCW) code = EV_ENC1_CCW + event_code_t'(2 * e);
            end
            enc_phase[e] = np;
            if (code != EV_NONE) begin
              if (n < MAX_RESULTS) codes[n] = code;
              n++;
              active_at = s.now_us;
            end
          end
        end
      end
      for (k = 0; k < SW_MAX; k++) begin
        gap = s.now_us - sw_since[k];
        if (lvl[k] != sw_cand[k]) begin
          sw_cand[k] = lvl[k];
          sw_since[k] = s.now_us;
        end else if (lvl[k] != sw_stable[k] && gap >= {8'd0, sw_debounce}) begin
          sw_stable[k] = lvl[k];
          if (k == 0) begin
            hold_armed = !lvl[k];
            hold_from = s.now_us;
          end
          code = lvl[k] ? EV_BUTTON_RELEASE : EV_BUTTON_PRESS;
          if (n < MAX_RESULTS) codes[n] = code + event_code_t'(2 * k);
          n++;
          active_at = s.now_us;
        end
      end
      if (hold_armed) begin
        lim = (hold_limit == 32'd0) ? 32'd1 : hold_limit;
        gap = s.now_us - hold_from;
        if (gap >= lim) begin
          hold_armed = 1'b0;
          if (n < MAX_RESULTS) codes[n] = EV_RESTART;
          n++;
        end
      end
    end
    if (n == 0) n = 1;
    if (n > MAX_RESULTS) n = MAX_RESULTS;
    idle = s.now_us - active_at;
    return n;
  endfunction

  // quadrature walks, switch changes, line noise and rare long time jumps
  function automatic sample_t next_random(input int unsigned scale);
    sample_t     s;
    int unsigned pick;
    int unsigned e;
    int unsigned k;
    int unsigned idx;
    logic [1:0]  ph;
    logic [1:0]  nx;
    logic [1:0]  walk [4];
    walk = '{PH_DETENT, PH_CW, PH_BOTH_LOW, PH_CCW};
    pick = $urandom_range(0, 99);
    s.edge_line = LINE_NONE;
    if (pick < 55) begin
      e = $urandom_range(0, 1);
      ph = (e == 0) ? pin_enc[3:2] : pin_enc[1:0];
      idx = 0;
      for (k = 0; k < 4; k++) if (walk[k] == ph) idx = k;
      nx = walk[$urandom_range(0, 1) ? (idx + 1) % 4 : (idx + 3) % 4];
      if (e == 0) pin_enc[3:2] = nx;
      else pin_enc[1:0] = nx;
      s.edge_line = 3'(2 * e + ((nx[1] != ph[1]) ? 1 : 2));
      // a short gap makes the edge a bounce
      if ($urandom_range(0, 6) == 0) clock_us += $urandom_range(0, scale / 8);
      else clock_us += $urandom_range(scale / 2, 2 * scale);
    end else if (pick < 80) begin
      k = $urandom_range(0, 2);
      if ($urandom_range(0, 4) < 2) pin_sw[k] = ~pin_sw[k];
      clock_us += $urandom_range(0, 3 * scale);
    end else if (pick < 97) begin
      s.edge_line = 3'($urandom_range(0, 7));
      pin_enc = 4'($urandom);
      if ($urandom_range(0, 3) == 0) pin_sw = 3'($urandom);
      clock_us += $urandom_range(0, scale);
    end else begin
      clock_us += $urandom;
    end
    s.now_us = clock_us;
    s.enc = pin_enc;
    s.sw = pin_sw;
    s.clear_idle = ($urandom_range(0, 15) == 0);
    return s;
  endfunction

  task automatic offer_sample(input sample_t s, input logic typed,
                              input event_code_t t_code, input logic [31:0] t_idle);
    event_code_t codes [MAX_RESULTS];
    logic [31:0] idle;
    int unsigned n;
    int unsigned i;
    while (!steady && $urandom_range(0, 99) < 29) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.now_us <= s.now_us;
    sample_ch.edge_line <= s.edge_line;
    sample_ch.enc1_a <= s.enc[3];
    sample_ch.enc1_b <= s.enc[2];
    sample_ch.enc2_a <= s.enc[1];
    sample_ch.enc2_b <= s.enc[0];
    sample_ch.button_level <= s.sw[2];
    sample_ch.enc1_sw_level <= s.sw[1];
    sample_ch.enc2_sw_level <= s.sw[0];
    sample_ch.clear_idle <= s.clear_idle;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    n = qualify_sample(s, codes, idle);
    if (typed) begin
      pending_events.push_back('{t_code, t_idle, 1'b1});
    end else begin
      for (i = 0; i < n; i++) pending_events.push_back('{codes[i], idle, i == n - 1});
    end
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENC_DEBOUNCE: enc_debounce = data[23:0];
      CFG_SW_DEBOUNCE:  sw_debounce = data[23:0];
      CFG_HOLD_LIMIT:   hold_limit = data;
      default: ;
    endcase
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      event_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      event_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (holdoff_taken != holdoff_asked) begin
      event_ch.ready <= 1'b0;
      stall_left <= 250;
      holdoff_taken <= holdoff_taken + 1;
    end else begin
      event_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (pending_events.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected event: code %0d idle %0d last %0b",
                   event_ch.event_code, event_ch.idle_us, event_ch.last_result);
      end else begin
        want = pending_events.pop_front();
        if (event_ch.event_code !== want.code || event_ch.idle_us !== want.idle ||
            event_ch.last_result !== want.last) begin
          bad_results++;
          if (bad_results <= 10)
            $display("event mismatch: expected code %0d idle %0d last %0b, got %0d %0d %0b",
                     want.code, want.idle, want.last, event_ch.event_code,
                     event_ch.idle_us, event_ch.last_result);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("encoder_switch_input_qualifier_test failed");
    $finish;
  end

  initial begin
    int p;
    int unsigned i;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ENC_DEBOUNCE;
    cfg_data <= 32'd0;
    sample_ch.valid <= 1'b0;
    sample_ch.now_us <= 32'd0;
    sample_ch.edge_line <= LINE_NONE;
    sample_ch.enc1_a <= 1'b1;
    sample_ch.enc1_b <= 1'b1;
    sample_ch.enc2_a <= 1'b1;
    sample_ch.enc2_b <= 1'b1;
    sample_ch.button_level <= 1'b1;
    sample_ch.enc1_sw_level <= 1'b1;
    sample_ch.enc2_sw_level <= 1'b1;
    sample_ch.clear_idle <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[r])
      offer_sample(directed_plan[r].s, directed_plan[r].typed,
                   directed_plan[r].code, directed_plan[r].idle);

    for (p = 0; p < 4; p++) begin
      if (p > 0) begin
        settle();
        write_reg(CFG_ENC_DEBOUNCE, phases[p].enc_db);
        write_reg(CFG_SW_DEBOUNCE, phases[p].sw_db);
        write_reg(CFG_HOLD_LIMIT, phases[p].hold);
      end
      for (i = 0; i < phases[p].count; i++) begin
        // fill the block while results are held off
        if (p == 0 && i == 30) holdoff_asked <= holdoff_asked + 1;
        if (p == 3 && i == 20) steady <= 1'b1;
        if (p == 3 && i == 80) steady <= 1'b0;
        offer_sample(next_random(phases[p].scale), 1'b0, EV_NONE, 32'd0);
      end
    end

    settle();
    if (bad_results == 0) begin
      $display("encoder_switch_input_qualifier_test passed");
    end else begin
      $display("encoder_switch_input_qualifier_test failed");
    end
    $finish;
  end

endmodule
